[design/ulfq_pkg.sv]
// Shared types and constants for the UART line framer queue.
// No dependencies; imported by the top level and the line memory.
package ulfq_pkg;

  localparam int LINE_MAX_DEFAULT    = 96;
  localparam int QUEUE_DEPTH_DEFAULT = 8;

  localparam int BYTE_W     = 8;
  localparam int LINE_LEN_W = 7;
  localparam int PENDING_W  = 4;

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic {
    ACT_RECEIVE = 1'b0,
    ACT_READ    = 1'b1
  } action_t;

endpackage

[design/ulfq_line_mem.sv]
// Line byte storage for the UART line framer queue: one write and one
// registered read port, addressed by ring slot and byte offset.
// Depends on ulfq_pkg.
module ulfq_line_mem #(
  parameter int LINE_MAX = ulfq_pkg::LINE_MAX_DEFAULT,
  parameter int SLOTS = ulfq_pkg::QUEUE_DEPTH_DEFAULT + 1,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int OFF_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [SLOT_W-1:0]           wr_slot,
  input  logic [OFF_W-1:0]            wr_off,
  input  logic [ulfq_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [SLOT_W-1:0]           rd_slot,
  input  logic [OFF_W-1:0]            rd_off,
  output logic [ulfq_pkg::BYTE_W-1:0] rd_data
);
  import ulfq_pkg::*;

  localparam int DEPTH  = SLOTS * LINE_MAX;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = ADDR_W'(ADDR_W'(wr_slot) * ADDR_W'(LINE_MAX) + ADDR_W'(wr_off));
  assign rd_addr = ADDR_W'(ADDR_W'(rd_slot) * ADDR_W'(LINE_MAX) + ADDR_W'(rd_off));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/uart_line_framer_queue.sv]
// Each input transfer passes the input register, then the result register
// with the line memory read alongside it. Throughput: one item per cycle
// while res_ready allows; the ring state is updated once per item.
// Reset (synchronous, active high) empties the ring and the line in
// assembly. The line memory holds no reset and needs no clearing pass.
module uart_line_framer_queue #(
  parameter int LINE_MAX = ulfq_pkg::LINE_MAX_DEFAULT,
  parameter int QUEUE_DEPTH = ulfq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [ulfq_pkg::BYTE_W-1:0]     rx_byte,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            out_valid,
  output logic [ulfq_pkg::BYTE_W-1:0]     out_byte,
  output logic                            last_of_line,
  output logic [ulfq_pkg::LINE_LEN_W-1:0] line_length,
  output logic [ulfq_pkg::PENDING_W-1:0]  lines_pending,
  output logic                            dropped_oldest,
  output logic                            overflow_reset
);
  import ulfq_pkg::*;

  localparam int SLOTS  = QUEUE_DEPTH + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEN_W  = $clog2(LINE_MAX + 1);
  localparam int OFF_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  logic              s1_valid;
  action_t           action_q;
  logic [BYTE_W-1:0] rx_q;
  logic              s2_load;

  logic [LEN_W-1:0]  asm_len, asm_len_next;
  logic [SLOT_W-1:0] head_slot, head_slot_next;
  logic [SLOT_W-1:0] tail_slot, tail_slot_next;
  logic [CNT_W-1:0]  line_count, line_count_next;
  logic [LEN_W-1:0]  read_offset, read_offset_next;
  logic [LEN_W-1:0]  front_len;
  logic [LEN_W-1:0]  length_store [SLOTS];

  logic              wr_req, len_we, rd_hit, drop, ovf, last;
  logic [LEN_W-1:0]  rd_off_full, off_plus;
  logic [BYTE_W-1:0] rd_data;

  logic              res_ov, res_last, res_drop, res_ovf;
  logic [LEN_W-1:0]  res_read_len;
  logic [LEN_W-1:0]  len_shown;

  assign s2_load  = s1_valid && (!res_valid || res_ready);
  assign in_ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      action_q <= action_t'(action);
      rx_q     <= rx_byte;
    end
  end

  always_comb begin
    asm_len_next     = asm_len;
    head_slot_next   = head_slot;
    tail_slot_next   = tail_slot;
    line_count_next  = line_count;
    read_offset_next = read_offset;
    wr_req = 1'b0;
    len_we = 1'b0;
    rd_hit = 1'b0;
    drop   = 1'b0;
    ovf    = 1'b0;
    last   = 1'b0;
    rd_off_full = (read_offset >= LEN_W'(LINE_MAX)) ? LEN_W'(LINE_MAX - 1) : read_offset;
    off_plus    = rd_off_full + LEN_W'(1);
    if (action_q == ACT_RECEIVE) begin
      if (rx_q == CHAR_CR) begin
        asm_len_next = asm_len;
      end else if (rx_q == CHAR_LF) begin
        if (asm_len != '0) begin
          len_we = 1'b1;
          head_slot_next = next_slot(head_slot);
          asm_len_next = '0;
          if (line_count >= CNT_W'(QUEUE_DEPTH)) begin
            drop = 1'b1;
            tail_slot_next = next_slot(tail_slot);
            read_offset_next = '0;
          end else begin
            line_count_next = line_count + CNT_W'(1);
          end
        end
      end else if (asm_len < LEN_W'(LINE_MAX)) begin
        wr_req = 1'b1;
        asm_len_next = asm_len + LEN_W'(1);
      end else begin
        ovf = 1'b1;
        asm_len_next = '0;
      end
    end else if (line_count != '0) begin
      rd_hit = 1'b1;
      if (off_plus >= front_len) begin
        last = 1'b1;
        tail_slot_next = next_slot(tail_slot);
        line_count_next = line_count - CNT_W'(1);
        read_offset_next = '0;
      end else begin
        read_offset_next = off_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_len     <= '0;
      head_slot   <= '0;
      tail_slot   <= '0;
      line_count  <= '0;
      read_offset <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (s2_load) begin
        asm_len     <= asm_len_next;
        head_slot   <= head_slot_next;
        tail_slot   <= tail_slot_next;
        line_count  <= line_count_next;
        read_offset <= read_offset_next;
        res_valid   <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (s2_load) begin
      res_ov       <= rd_hit;
      res_last     <= last;
      res_drop     <= drop;
      res_ovf      <= ovf;
      res_read_len <= front_len;
    end
  end

  // Length of the oldest line is kept registered; a line pushed in the same
  // step that becomes the oldest is taken from the assembly length.
  always_ff @(posedge clk) begin
    if (s2_load && len_we) begin
      length_store[head_slot] <= asm_len;
    end
    if (s2_load) begin
      if (len_we && head_slot == tail_slot_next) begin
        front_len <= asm_len;
      end else begin
        front_len <= length_store[tail_slot_next];
      end
    end
  end

  ulfq_line_mem #(
    .LINE_MAX (LINE_MAX),
    .SLOTS    (SLOTS)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (s2_load && wr_req),
    .wr_slot (head_slot),
    .wr_off  (asm_len[OFF_W-1:0]),
    .wr_data (rx_q),
    .rd_en   (s2_load && rd_hit),
    .rd_slot (tail_slot),
    .rd_off  (rd_off_full[OFF_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    if (res_ov) begin
      len_shown = res_read_len;
    end else if (line_count != '0) begin
      len_shown = front_len;
    end else begin
      len_shown = '0;
    end
  end

  assign out_valid      = res_ov;
  assign out_byte       = res_ov ? rd_data : '0;
  assign last_of_line   = res_last;
  assign line_length    = LINE_LEN_W'(len_shown);
  assign lines_pending  = PENDING_W'(line_count);
  assign dropped_oldest = res_drop;
  assign overflow_reset = res_ovf;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= CNT_W'(QUEUE_DEPTH))
    else $error("Queued line count exceeds the ring depth.");

  a_asm_bound: assert property (@(posedge clk) disable iff (rst)
    asm_len <= LEN_W'(LINE_MAX))
    else $error("Assembly length exceeds the line size.");

  a_ring_span: assert property (@(posedge clk) disable iff (rst)
    ((int'(tail_slot) + int'(line_count)) % SLOTS) == int'(head_slot))
    else $error("Head and tail slots disagree with the line count.");

  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    line_count != '0 |-> read_offset < front_len)
    else $error("Read offset runs past the oldest line.");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_drop |-> line_count == CNT_W'(QUEUE_DEPTH))
    else $error("A dropped line was reported with the ring not full.");

  a_last_is_read: assert property (@(posedge clk) disable iff (rst)
    s2_load && last |=> res_ov && line_count == $past(line_count) - CNT_W'(1))
    else $error("Final byte transfer did not remove exactly one line.");
`endif

endmodule

[tb/sv/uart_line_framer_queue_tb.sv]
`timescale 1ns / 100ps
// Testbench for uart_line_framer_queue: frames random UART traffic into lines and drains them.
// A local line queue predictor checks every result; depends only on ulfq_pkg and the DUT.
module uart_line_framer_queue_tb;
  import ulfq_pkg::*;

  localparam int LMAX = LINE_MAX_DEFAULT;
  localparam int QDEPTH = QUEUE_DEPTH_DEFAULT;
  localparam int SLOTS = QDEPTH + 1;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct {
    action_t act;
    logic [BYTE_W-1:0] data;
    int phase;
  } stim_item_t;

  typedef struct packed {
    logic ov;
    logic [BYTE_W-1:0] ob;
    logic last;
    logic [LINE_LEN_W-1:0] len;
    logic [PENDING_W-1:0] pend;
    logic drop;
    logic ovf;
  } line_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic action = 1'b0;
  logic [BYTE_W-1:0] rx_byte = '0;
  logic res_ready = 1'b0;
  logic in_ready, res_valid, out_valid, last_of_line, dropped_oldest, overflow_reset;
  logic [BYTE_W-1:0] out_byte;
  logic [LINE_LEN_W-1:0] line_length;
  logic [PENDING_W-1:0] lines_pending;

  stim_item_t stim_q[$];
  stim_item_t drv_item;
  line_result_t expected_q[$];
  line_result_t want, got;
  int total_items, accepted, errors;
  int cur_phase = 0;
  bit in_taken = 0;
  logic hold_off = 1'b0;
  int send_idle_pct[4] = '{0, 87, 0, 17};
  int recv_stall_pct[4] = '{0, 0, 87, 17};
  int n_bytes_read, n_empty_reads, n_drops, n_overflows, n_lines_done;

  logic [BYTE_W-1:0] line_mem[0:SLOTS*LMAX-1];
  int slot_len[0:SLOTS-1];
  int asm_len, head, tail, q_count, rd_off;

  uart_line_framer_queue DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_ready(res_ready),
    .out_valid(out_valid), .out_byte(out_byte), .last_of_line(last_of_line),
    .line_length(line_length), .lines_pending(lines_pending),
    .dropped_oldest(dropped_oldest), .overflow_reset(overflow_reset)
  );

  always #5 clk = ~clk;

  function automatic void drop_oldest_line();
    tail = (tail + 1) % SLOTS;
    q_count--;
    rd_off = 0;
  endfunction

  function automatic line_result_t line_queue_step(action_t act, logic [BYTE_W-1:0] b);
    line_result_t r;
    bit len_set;
    r = '0;
    len_set = 0;
    if (act == ACT_RECEIVE) begin
      if (b == CHAR_LF) begin
        if (asm_len != 0) begin
          if (q_count >= QDEPTH) begin
            drop_oldest_line();
            r.drop = 1'b1;
          end
          slot_len[head] = asm_len;
          head = (head + 1) % SLOTS;
          q_count++;
          asm_len = 0;
        end
      end else if (b != CHAR_CR) begin
        if (asm_len < LMAX) begin
          line_mem[head*LMAX + asm_len] = b;
          asm_len++;
        end else begin
          asm_len = 0;
          r.ovf = 1'b1;
        end
      end
    end else if (q_count != 0) begin
      r.ov = 1'b1;
      r.ob = line_mem[tail*LMAX + rd_off];
      r.len = LINE_LEN_W'(slot_len[tail]);
      len_set = 1;
      if (rd_off + 1 >= slot_len[tail]) begin
        r.last = 1'b1;
        drop_oldest_line();
      end else begin
        rd_off++;
      end
    end
    if (!len_set) r.len = LINE_LEN_W'((q_count != 0) ? slot_len[tail] : 0);
    r.pend = PENDING_W'(q_count);
    return r;
  endfunction

  function automatic void check_field(string name, logic [BYTE_W-1:0] exp_v,
                                      logic [BYTE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic add_item(action_t act, logic [BYTE_W-1:0] b);
    stim_item_t it;
    it.act = act;
    it.data = b;
    it.phase = 0;
    stim_q.push_back(it);
  endtask

  function automatic logic [BYTE_W-1:0] rand_data();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // Checks each result transfer against the oldest prediction, then predicts the accepted input.
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 0;
    end else begin
      if (res_valid && res_ready) begin
        got = '{out_valid, out_byte, last_of_line, line_length, lines_pending,
                dropped_oldest, overflow_reset};
        if (expected_q.size() == 0) begin
          $error("result transfer with no result expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_valid", want.ov, got.ov);
          check_field("out_byte", want.ob, got.ob);
          check_field("last_of_line", want.last, got.last);
          check_field("line_length", want.len, got.len);
          check_field("lines_pending", want.pend, got.pend);
          check_field("dropped_oldest", want.drop, got.drop);
          check_field("overflow_reset", want.ovf, got.ovf);
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        want = line_queue_step(action_t'(action), rx_byte);
        expected_q.push_back(want);
        accepted++;
        n_bytes_read += int'(want.ov);
        n_lines_done += int'(want.last);
        n_drops += int'(want.drop);
        n_overflows += int'(want.ovf);
        if (action == ACT_READ && !want.ov) n_empty_reads++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct[stim_q[0].phase]) begin
        drv_item = stim_q.pop_front();
        in_valid <= 1'b1;
        action <= drv_item.act;
        rx_byte <= drv_item.data;
        cur_phase <= drv_item.phase;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    res_ready <= !rst && !hold_off && ($urandom_range(0, 99) >= recv_stall_pct[cur_phase]);
  end

  initial begin
    wait (accepted >= 100);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (200) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int r, n;
    asm_len = 0;
    head = 0;
    tail = 0;
    q_count = 0;
    rd_off = 0;

    add_item(ACT_READ, 8'hA5);
    add_item(ACT_RECEIVE, CHAR_CR);
    add_item(ACT_RECEIVE, CHAR_LF);
    add_item(ACT_RECEIVE, 8'h00);
    add_item(ACT_RECEIVE, 8'hFF);
    add_item(ACT_RECEIVE, CHAR_CR);
    add_item(ACT_RECEIVE, 8'h7F);
    add_item(ACT_RECEIVE, CHAR_LF);
    add_item(ACT_READ, 8'h5A);
    // Eight more lines overrun the ring while the first one is partly read.
    for (int i = 0; i < QDEPTH; i++) begin
      add_item(ACT_RECEIVE, 8'h80 | BYTE_W'(i));
      add_item(ACT_RECEIVE, CHAR_LF);
    end
    add_item(ACT_READ, 8'hFF);
    add_item(ACT_READ, 8'h00);

    while (stim_q.size() < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        n = ($urandom_range(0, 99) < 3) ? $urandom_range(LMAX - 2, LMAX + 4)
                                        : $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 19) == 0) add_item(ACT_RECEIVE, CHAR_CR);
          add_item(ACT_RECEIVE, rand_data());
        end
        if ($urandom_range(0, 3) == 0) add_item(ACT_RECEIVE, CHAR_CR);
        add_item(ACT_RECEIVE, CHAR_LF);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 16)) add_item(ACT_READ, BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_item(action_t'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
        end
      end
    end
    total_items = stim_q.size();
    for (int i = 0; i < total_items; i++) stim_q[i].phase = i * 4 / total_items;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted < total_items || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d items, %0d bytes read in %0d lines, %0d reads on an empty queue",
             total_items, n_bytes_read, n_lines_done, n_empty_reads);
    $display("summary: %0d oldest-line drops, %0d line overflows, %0d mismatches",
             n_drops, n_overflows, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
